### sv/graph_vertex_coloring_defines.svh
// ----------------------------------------------------------------------------
// graph_vertex_coloring_defines
// Assertion macros shared by the coloring block.
// ----------------------------------------------------------------------------
`ifndef GRAPH_VERTEX_COLORING_DEFINES_SVH
`define GRAPH_VERTEX_COLORING_DEFINES_SVH

// clocked check, off while in reset
`define GVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also during reset
`define GVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/gvc_pkg.sv
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared constants, types and helpers of the graph coloring block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gvc_pkg;
  localparam int N    = 32;
  localparam int IW   = $clog2(N);
  localparam int CW   = 5;
  localparam int CNTW = 6;

  localparam logic [1:0] MODE_GREEDY = 2'd0;
  localparam logic [1:0] MODE_WP     = 2'd1;
  localparam logic [1:0] MODE_DSATUR = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_ORDER_MODE = 1'b1;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  typedef struct packed {
    logic          add_edge;
    logic          clear_run;
    logic          scan;
    logic          scan_first;
    logic          commit;
    logic          load_out;
    logic          last;
    logic [IW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic            best_valid;
    logic            out_free;
    logic [CNTW-1:0] n_eff;
  } stat_t;

  function automatic logic [CNTW-1:0] popcount(input logic [N-1:0] v);
    logic [CNTW-1:0] s;
    s = '0;
    for (int k = 0; k < N; k++) s = s + CNTW'(v[k]);
    return s;
  endfunction

  function automatic logic [CW-1:0] lowest_free(input logic [N-1:0] set);
    logic [CW-1:0] c;
    c = CW'(N - 1);
    for (int k = N - 1; k >= 0; k--) if (!set[k]) c = CW'(k);
    return c;
  endfunction
endpackage
`default_nettype wire

### sv/graph_vertex_coloring.sv
// ----------------------------------------------------------------------------
// graph_vertex_coloring
// Greedy, Welsh-Powell and DSATUR vertex coloring of a graph of up to 32 nodes.
// ----------------------------------------------------------------------------
// An edge transfer (tuser 0) sets a symmetric bit in the adjacency matrix;
// self loops, repeats and out-of-range endpoints are dropped. A run transfer
// (tuser 1) clears the color state in its accepting cycle and then colors n
// nodes, each step being a scan over the n matrix rows followed by a commit.
// A last scan finds no node left, after which the n results leave one per
// cycle while the receiver is ready, in index order, with tlast on the final
// node. The input is not ready during a run or until the last result has
// been loaded into the output register.
`timescale 1ns / 1ps
`default_nettype none
module graph_vertex_coloring (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire        cfg_idx,
  input  wire [5:0]  cfg_data,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,   // node_a[4:0], node_b[9:5], zero[15:10]
  input  wire        in_tuser,   // func
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [15:0] out_tdata, // node_index[4:0], node_color[9:5], color_count[15:10]
  output logic       out_tlast
);
  import gvc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  gvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  gvc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .node_a     (in_tdata[4:0]),
    .node_b     (in_tdata[9:5]),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule
`default_nettype wire

### sv/gvc_dp.sv
// ----------------------------------------------------------------------------
// gvc_dp
// Datapath: adjacency matrix, color state, node selection and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gvc_dp (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire                      cfg_idx,
  input  wire [5:0]                cfg_data,
  input  wire [gvc_pkg::IW-1:0]    node_a,
  input  wire [gvc_pkg::IW-1:0]    node_b,
  input  gvc_pkg::cmd_t            cmd,
  output gvc_pkg::stat_t           st,
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output logic [15:0]              out_tdata,
  output logic                     out_tlast
);
  import gvc_pkg::*;

  logic [CNTW-1:0] node_count_r;
  logic [1:0]      order_mode_r;
  logic [N-1:0]    adj_r [N];
  logic [N-1:0]    ncs_r [N];
  logic [CW-1:0]   color_r [N];
  logic [N-1:0]    colored_r;
  logic [IW-1:0]   best_r, best_nxt;
  logic            bv_r, bv_nxt;
  logic [CNTW-1:0] bs_r, bs_nxt, bd_r, bd_nxt;
  logic [CW-1:0]   top_r;
  logic            ov_r;
  logic [15:0]     od_r;
  logic            ol_r;

  logic [CNTW-1:0] n_eff;
  logic [N-1:0]    mask;
  logic [CNTW-1:0] deg, sat;
  logic            bv_base, better;
  logic [CW-1:0]   new_c;
  logic [N-1:0]    nb;
  logic            edge_ok;

  always_comb begin
    if (node_count_r == '0) n_eff = CNTW'(1);
    else if (node_count_r > CNTW'(N)) n_eff = CNTW'(N);
    else n_eff = node_count_r;
    for (int k = 0; k < N; k++) mask[k] = CNTW'(k) < n_eff;
  end

  always_comb begin
    deg     = popcount(adj_r[cmd.idx] & mask);
    sat     = (order_mode_r == MODE_DSATUR) ? popcount(ncs_r[cmd.idx]) : '0;
    bv_base = cmd.scan_first ? 1'b0 : bv_r;
    better  = !bv_base ||
              ((order_mode_r == MODE_WP || order_mode_r == MODE_DSATUR) &&
               (sat > bs_r || (sat == bs_r && deg > bd_r)));
    best_nxt = best_r;
    bv_nxt   = bv_base;
    bs_nxt   = bs_r;
    bd_nxt   = bd_r;
    if (!colored_r[cmd.idx] && better) begin
      best_nxt = cmd.idx;
      bv_nxt   = 1'b1;
      bs_nxt   = sat;
      bd_nxt   = deg;
    end
  end

  assign new_c   = lowest_free(ncs_r[best_r]);
  assign nb      = adj_r[best_r] & mask & ~colored_r;
  assign edge_ok = (CNTW'(node_a) < n_eff) && (CNTW'(node_b) < n_eff) && (node_a != node_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNTW'(1);
      order_mode_r <= MODE_GREEDY;
    end else if (cfg_we) begin
      if (cfg_idx == REG_NODE_COUNT) node_count_r <= cfg_data;
      else order_mode_r <= cfg_data[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) adj_r[k] <= '0;
    end else if (cmd.add_edge && edge_ok) begin
      adj_r[node_a][node_b] <= 1'b1;
      adj_r[node_b][node_a] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colored_r <= '0;
      top_r     <= '0;
      bv_r      <= 1'b0;
      for (int k = 0; k < N; k++) ncs_r[k] <= '0;
    end else if (cmd.clear_run) begin
      colored_r <= '0;
      top_r     <= '0;
      bv_r      <= 1'b0;
      for (int k = 0; k < N; k++) ncs_r[k] <= '0;
    end else if (cmd.scan) begin
      bv_r <= bv_nxt;
    end else if (cmd.commit) begin
      colored_r[best_r] <= 1'b1;
      if (new_c > top_r) top_r <= new_c;
      for (int k = 0; k < N; k++) if (nb[k] && k != int'(best_r)) ncs_r[k][new_c] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      best_r <= best_nxt;
      bs_r   <= bs_nxt;
      bd_r   <= bd_nxt;
    end
    if (cmd.commit) color_r[best_r] <= new_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load_out) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      od_r <= {CNTW'(top_r) + CNTW'(1), color_r[cmd.idx], cmd.idx};
      ol_r <= cmd.last;
    end
  end

  assign st.best_valid = bv_r;
  assign st.out_free   = !ov_r || out_tready;
  assign st.n_eff      = n_eff;
  assign out_tvalid    = ov_r;
  assign out_tdata     = od_r;
  assign out_tlast     = ol_r;
endmodule
`default_nettype wire

### sv/gvc_ctrl.sv
// ----------------------------------------------------------------------------
// gvc_ctrl
// Controller: edge loading, selection scans, coloring steps and result emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "graph_vertex_coloring_defines.svh"
module gvc_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_tvalid,
  input  wire            in_tuser,
  output logic           in_tready,
  output gvc_pkg::cmd_t  cmd,
  input  gvc_pkg::stat_t st
);
  import gvc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          at_end;

  assign at_end    = (CNTW'(idx_r) + CNTW'(1)) == st.n_eff;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == FUNC_EDGE) begin
            cmd.add_edge = 1'b1;
          end else begin
            cmd.clear_run = 1'b1;
            idx_nxt       = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan       = 1'b1;
        cmd.scan_first = (idx_r == '0);
        if (at_end) state_nxt = S_COMMIT;
        else idx_nxt = idx_r + IW'(1);
      end
      S_COMMIT: begin
        idx_nxt = '0;
        if (st.best_valid) begin
          cmd.commit = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          cmd.last     = at_end;
          if (at_end) state_nxt = S_IDLE;
          else idx_nxt = idx_r + IW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `GVC_ASSERT(a_commit_rescan, (state_r == S_COMMIT && st.best_valid) |=> (state_r == S_SCAN), "commit must start a new scan")
  `GVC_ASSERT(a_last_idle, (cmd.load_out && cmd.last) |=> (state_r == S_IDLE), "last result must end the run")
  `GVC_ASSERT(a_idx_range, (state_r == S_SCAN || state_r == S_EMIT) |-> (CNTW'(idx_r) < st.n_eff), "node index beyond node count")
  `GVC_ASSERT_ALWAYS(a_load_free, cmd.load_out |-> st.out_free, "result loaded over pending transfer")
endmodule
`default_nettype wire

### sim/graph_vertex_coloring_test.sv
// ----------------------------------------------------------------------------
// graph_vertex_coloring_test
// Loads random and directed edge sets, runs greedy, Welsh-Powell and DSATUR
// coloring at several node counts and checks every node's color, the color
// count and tlast against a behavioral coloring predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module graph_vertex_coloring_test;
  import gvc_pkg::*;

  typedef struct packed {
    logic           func;
    logic [4:0]     a;
    logic [4:0]     b;
  } edge_item_t;

  typedef struct packed {
    logic [4:0] idx;
    logic [4:0] color;
    logic [5:0] count;
    logic       last;
  } color_result_t;

  logic clk, rst_n;
  logic cfg_we, cfg_idx;
  logic [5:0] cfg_data;
  logic in_tvalid, in_tready, in_tuser;
  logic [15:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [15:0] out_tdata;

  graph_vertex_coloring uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // predictor state
  logic [31:0] adj [32];
  logic [4:0]  node_col [32];
  logic [5:0]  nodes_reg;
  logic [1:0]  mode_reg;

  edge_item_t    pending_items[$];
  color_result_t expected_colors[$];
  int errors = 0;
  int accepted = 0;
  int queued = 0;
  bit calm = 0;
  bit in_took = 0;
  int hold_off = 0;
  longint cycles = 0;

  function automatic int eff_nodes();
    int n;
    n = int'(nodes_reg);
    if (n < 1) n = 1;
    if (n > 32) n = 32;
    return n;
  endfunction

  function automatic int ones(logic [31:0] v);
    int c;
    c = 0;
    for (int k = 0; k < 32; k++) c += int'(v[k]);
    return c;
  endfunction

  task automatic expect_result(color_result_t r);
    expected_colors.insert(expected_colors.size(), r);
  endtask

  task automatic predict_transfer(edge_item_t it);
    int n, u, top, best, bsat, bdeg, sat, deg, c;
    logic [31:0] mask, done;
    logic [31:0] nset [32];
    n = eff_nodes();
    mask = (n == 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
    if (it.func == FUNC_EDGE) begin
      if (it.a < n && it.b < n && it.a != it.b) begin
        adj[it.a][it.b] = 1'b1;
        adj[it.b][it.a] = 1'b1;
      end
      return;
    end
    done = '0;
    top = 0;
    for (int i = 0; i < 32; i++) nset[i] = '0;
    for (int k = 0; k < n; k++) begin
      best = -1; bsat = 0; bdeg = 0;
      for (int i = 0; i < n; i++) begin
        if (done[i]) continue;
        if (mode_reg != MODE_WP && mode_reg != MODE_DSATUR) begin
          best = i;
          break;
        end
        deg = ones(adj[i] & mask);
        sat = (mode_reg == MODE_DSATUR) ? ones(nset[i]) : 0;
        if (best < 0 || sat > bsat || (sat == bsat && deg > bdeg)) begin
          best = i; bsat = sat; bdeg = deg;
        end
      end
      u = best;
      c = 31;
      for (int j = 31; j >= 0; j--) if (!nset[u][j]) c = j;
      node_col[u] = c[4:0];
      done[u] = 1'b1;
      if (c > top) top = c;
      for (int i = 0; i < n; i++)
        if (adj[u][i] && !done[i]) nset[i][c] = 1'b1;
    end
    for (int i = 0; i < n; i++)
      expect_result('{i[4:0], node_col[i], 6'(top + 1), i == n - 1});
  endtask

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // driver
  int gap_in = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        void'(pending_items.pop_front());
        accepted++;
        if (!calm && $urandom_range(0, 7) == 0) gap_in = $urandom_range(1, 5);
      end
      if (gap_in > 0) begin
        gap_in--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_items[0].func;
        in_tdata  <= {6'd0, pending_items[0].b, pending_items[0].a};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // predictor follows accepted transfers at the rising edge
  always @(posedge clk) begin
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took)
      predict_transfer('{in_tuser, in_tdata[4:0], in_tdata[9:5]});
  end

  // receiver stall
  int gap_out = 0;
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_tready <= 1'b0;
    end else if (gap_out > 0) begin
      gap_out--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) gap_out = $urandom_range(1, 5);
    end
  end

  // monitor
  always @(posedge clk) begin
    color_result_t got, want;
    cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[4:0], out_tdata[9:5], out_tdata[15:10], out_tlast};
      if (expected_colors.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, got);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
    if (cycles > 3_000_000) begin
      $display("graph_vertex_coloring_test failed");
      $finish;
    end
  end

  task automatic add_item(logic f, logic [4:0] a, logic [4:0] b);
    pending_items.insert(pending_items.size(), '{f, a, b});
    queued++;
  endtask

  task automatic wait_drained();
    while (accepted < queued || expected_colors.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [5:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NODE_COUNT) nodes_reg = val;
    else mode_reg = val[1:0];
  endtask

  // random graph phase: mostly in-range edges, some out of range, then a run
  task automatic random_graph(int edges);
    int n;
    n = eff_nodes();
    for (int k = 0; k < edges; k++) begin
      if ($urandom_range(0, 7) == 0)
        add_item(FUNC_EDGE, 5'($urandom), 5'($urandom));
      else
        add_item(FUNC_EDGE, 5'($urandom_range(0, n - 1)), 5'($urandom_range(0, n - 1)));
    end
    add_item(FUNC_RUN, 5'($urandom), 5'($urandom));
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = 1'b0; cfg_data = '0;
    in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0; out_tready = 1'b0;
    nodes_reg = 6'd1; mode_reg = MODE_GREEDY;
    for (int i = 0; i < 32; i++) begin
      adj[i] = '0;
      node_col[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: default single node run, then a small graph in all modes
    add_item(FUNC_RUN, 5'd31, 5'd31);
    wait_drained();
    write_reg(REG_NODE_COUNT, 6'd32);
    add_item(FUNC_EDGE, 5'd0, 5'd31);
    add_item(FUNC_EDGE, 5'd31, 5'd0);
    add_item(FUNC_EDGE, 5'd3, 5'd3);
    add_item(FUNC_EDGE, 5'd1, 5'd2);
    add_item(FUNC_EDGE, 5'd2, 5'd3);
    add_item(FUNC_EDGE, 5'd3, 5'd1);
    add_item(FUNC_EDGE, 5'd4, 5'd1);
    add_item(FUNC_RUN, 5'd0, 5'd0);
    wait_drained();
    write_reg(REG_ORDER_MODE, 6'(MODE_WP));
    add_item(FUNC_RUN, 5'd0, 5'd0);
    wait_drained();
    write_reg(REG_ORDER_MODE, 6'(MODE_DSATUR));
    add_item(FUNC_RUN, 5'd0, 5'd0);
    wait_drained();
    // lowered node count masks neighbors; out-of-range endpoint dropped
    write_reg(REG_NODE_COUNT, 6'd3);
    add_item(FUNC_EDGE, 5'd0, 5'd5);
    add_item(FUNC_RUN, 5'd0, 5'd0);
    wait_drained();
    write_reg(REG_ORDER_MODE, 6'd3);
    write_reg(REG_NODE_COUNT, 6'd0);
    add_item(FUNC_RUN, 5'd0, 5'd0);
    wait_drained();
    write_reg(REG_NODE_COUNT, 6'd63);
    add_item(FUNC_RUN, 5'd0, 5'd0);
    // long receiver hold past the end of the run while edges keep coming
    hold_off = 1500;
    random_graph(6);
    wait_drained();

    // random phases: edges accumulate, mostly small node counts
    for (int p = 0; p < 14; p++) begin
      write_reg(REG_ORDER_MODE, 6'($urandom_range(0, 3)));
      write_reg(REG_NODE_COUNT, (p % 5 == 4) ? 6'd32 : 6'($urandom_range(2, 12)));
      if (p == 10) calm = 1;
      random_graph($urandom_range(8, 24));
      wait_drained();
    end

    if (errors == 0) $display("graph_vertex_coloring_test passed");
    else $display("graph_vertex_coloring_test failed");
    $finish;
  end
endmodule
